[rtl/tcc_pkg.sv]
// Shared constants and the CORDIC arctangent table for the tilt-compensated compass.
// No dependencies; used by tcc_div, tcc_cordic and the top module under rtl/, not by tcc_sqrt.
package tcc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int Q_BITS          = 16;
    localparam int FRAC            = 15;
    localparam int CORDIC_STEPS    = 18;
    localparam int ANG_BITS        = 27;
    localparam int ANG_FRAC        = 16;
    localparam int TEN_BITS        = 12;
    localparam int ROLL_BITS       = 11;

    localparam logic signed [ANG_BITS-1:0] ANG_180 = 27'sd11796480;
    localparam logic [Q_BITS-1:0]          Q15_MAX = 16'h7FFF;
    localparam logic [31:0]                Q30_ONE = 32'h4000_0000;

    // atan(2^-i) in degrees * 2^16, rounded
    function automatic logic signed [ANG_BITS-1:0] atan_step(input int unsigned i);
        case (i)
            0:       return 27'sd2949120;
            1:       return 27'sd1740967;
            2:       return 27'sd919879;
            3:       return 27'sd466945;
            4:       return 27'sd234379;
            5:       return 27'sd117304;
            6:       return 27'sd58666;
            7:       return 27'sd29335;
            8:       return 27'sd14668;
            9:       return 27'sd7334;
            10:      return 27'sd3667;
            11:      return 27'sd1833;
            12:      return 27'sd917;
            13:      return 27'sd458;
            14:      return 27'sd229;
            15:      return 27'sd115;
            16:      return 27'sd57;
            17:      return 27'sd29;
            default: return '0;
        endcase
    endfunction

endpackage

[rtl/tcc_sqrt.sv]
// Pipelined integer floor square root, one result bit per stage, NL lanes in parallel.
// Side data travels with each item. Depends on nothing but its parameters.
module tcc_sqrt #(
    parameter int VW = 32,
    parameter int NL = 2,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [SW-1:0]   i_side,
    input  logic [VW-1:0]   i_val [NL],
    output logic            o_valid,
    output logic [SW-1:0]   o_side,
    output logic [VW/2-1:0] o_root [NL]
);
    localparam int STEPS = VW / 2;

    logic [VW-1:0]    r_v    [STEPS][NL];
    logic [VW-1:0]    r_r    [STEPS][NL];
    logic [VW-1:0]    n_v    [STEPS][NL];
    logic [VW-1:0]    n_r    [STEPS][NL];
    logic [SW-1:0]    r_side [STEPS];
    logic [STEPS-1:0] r_valid;

    always_comb begin
        logic [VW-1:0] pv;
        logic [VW-1:0] pr;
        logic [VW-1:0] sum;
        logic [VW-1:0] bitv;
        for (int k = 0; k < STEPS; k++) begin
            bitv = VW'(1) << (VW - 2 - 2 * k);
            for (int l = 0; l < NL; l++) begin
                if (k == 0) begin
                    pv = i_val[l];
                    pr = '0;
                end else begin
                    pv = r_v[k-1][l];
                    pr = r_r[k-1][l];
                end
                sum = pr + bitv;
                if (pv >= sum) begin
                    n_v[k][l] = pv - sum;
                    n_r[k][l] = (pr >> 1) + bitv;
                end else begin
                    n_v[k][l] = pv;
                    n_r[k][l] = pr >> 1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < STEPS; k++) begin
                r_v[k] <= n_v[k];
                r_r[k] <= n_r[k];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            o_root[l] = r_r[STEPS-1][l][VW/2-1:0];
        end
    end

    assign o_valid = r_valid[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

[rtl/tcc_div.sv]
// Pipelined restoring divider giving a signed Q1.15 ratio mag / root, saturated to 32767.
// One quotient bit per stage plus a sign stage. Uses tcc_pkg.
module tcc_div #(
    parameter int MW = 16,
    parameter int NL = 2,
    parameter int SW = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [SW-1:0]                       i_side,
    input  logic [MW-1:0]                       i_mag [NL],
    input  logic [MW-1:0]                       i_den [NL],
    input  logic [NL-1:0]                       i_neg,
    output logic                                o_valid,
    output logic [SW-1:0]                       o_side,
    output logic signed [tcc_pkg::Q_BITS-1:0]   o_q [NL]
);
    localparam int QB    = tcc_pkg::Q_BITS;
    localparam int STEPS = QB;
    localparam int RW    = MW + QB;

    logic [RW-1:0]         r_rem [STEPS][NL];
    logic [QB-1:0]         r_q   [STEPS][NL];
    logic [MW-1:0]         r_den [STEPS][NL];
    logic [RW-1:0]         n_rem [STEPS][NL];
    logic [QB-1:0]         n_q   [STEPS][NL];
    logic [NL-1:0]         r_neg [STEPS];
    logic [SW-1:0]         r_side [STEPS+1];
    logic [STEPS:0]        r_valid;
    logic signed [QB-1:0]  r_out [NL];
    logic signed [QB-1:0]  n_out [NL];

    always_comb begin
        logic [RW-1:0] pr;
        logic [QB-1:0] pq;
        logic [MW-1:0] pd;
        logic [RW-1:0] d;
        for (int k = 0; k < STEPS; k++) begin
            for (int l = 0; l < NL; l++) begin
                if (k == 0) begin
                    pr = RW'(i_mag[l]) << tcc_pkg::FRAC;
                    pq = '0;
                    pd = i_den[l];
                end else begin
                    pr = r_rem[k-1][l];
                    pq = r_q[k-1][l];
                    pd = r_den[k-1][l];
                end
                d = RW'(pd) << (STEPS - 1 - k);
                if (pr >= d) begin
                    n_rem[k][l] = pr - d;
                    n_q[k][l]   = {pq[QB-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = pr;
                    n_q[k][l]   = {pq[QB-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        logic [QB-1:0] qs;
        for (int l = 0; l < NL; l++) begin
            qs = r_q[STEPS-1][l][QB-1] ? tcc_pkg::Q15_MAX : r_q[STEPS-1][l];
            n_out[l] = r_neg[STEPS-1][l] ? -$signed(qs) : $signed(qs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[STEPS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                for (int l = 0; l < NL; l++) begin
                    r_den[k][l] <= (k == 0) ? i_den[l] : r_den[k-1][l];
                end
                r_neg[k] <= (k == 0) ? i_neg : r_neg[k-1];
            end
            for (int k = 0; k <= STEPS; k++) begin
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid[STEPS];
    assign o_side  = r_side[STEPS];
    assign o_q     = r_out;

endmodule

[rtl/tcc_cordic.sv]
// Pipelined vectoring CORDIC: atan2(y, x) in tenths of a degree, truncated toward zero.
// One pre-rotation stage, one stage per iteration, one scaling stage. Uses tcc_pkg.
module tcc_cordic #(
    parameter int IW = 48,
    parameter int NL = 3,
    parameter int SW = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [SW-1:0]                         i_side,
    input  logic signed [IW-1:0]                  i_x [NL],
    input  logic signed [IW-1:0]                  i_y [NL],
    output logic                                  o_valid,
    output logic [SW-1:0]                         o_side,
    output logic signed [tcc_pkg::TEN_BITS-1:0]   o_tenths [NL]
);
    localparam int XW = IW + 3;
    localparam int NS = tcc_pkg::CORDIC_STEPS;
    localparam int ZW = tcc_pkg::ANG_BITS;
    localparam int PW = ZW + 4;
    localparam int TW = tcc_pkg::TEN_BITS;
    localparam logic signed [PW-1:0] RND = PW'((1 << tcc_pkg::ANG_FRAC) - 1);

    logic signed [XW-1:0] r_x [NS+1][NL];
    logic signed [XW-1:0] r_y [NS+1][NL];
    logic signed [ZW-1:0] r_z [NS+1][NL];
    logic [NL-1:0]        r_fix [NS+1];
    logic signed [XW-1:0] n_x [NS+1][NL];
    logic signed [XW-1:0] n_y [NS+1][NL];
    logic signed [ZW-1:0] n_z [NS+1][NL];
    logic [NL-1:0]        n_fix [NS+1];
    logic [SW-1:0]        r_side [NS+2];
    logic [NS+1:0]        r_valid;
    logic signed [TW-1:0] r_t [NL];
    logic signed [TW-1:0] n_t [NL];

    always_comb begin
        logic signed [XW-1:0] px;
        logic signed [XW-1:0] py;
        logic signed [ZW-1:0] pz;
        logic                 pf;
        for (int l = 0; l < NL; l++) begin
            px = XW'(i_x[l]);
            py = XW'(i_y[l]);
            n_fix[0][l] = (py == 0);
            n_x[0][l] = px;
            n_y[0][l] = py;
            n_z[0][l] = '0;
            if (py == 0) begin
                n_z[0][l] = (px < 0) ? tcc_pkg::ANG_180 : '0;
            end else if (px < 0) begin
                n_z[0][l] = (py > 0) ? tcc_pkg::ANG_180 : -tcc_pkg::ANG_180;
                n_x[0][l] = -px;
                n_y[0][l] = -py;
            end
        end
        for (int k = 0; k < NS; k++) begin
            for (int l = 0; l < NL; l++) begin
                px = r_x[k][l];
                py = r_y[k][l];
                pz = r_z[k][l];
                pf = r_fix[k][l];
                n_fix[k+1][l] = pf;
                if (pf) begin
                    n_x[k+1][l] = px;
                    n_y[k+1][l] = py;
                    n_z[k+1][l] = pz;
                end else if (py > 0) begin
                    n_x[k+1][l] = px + (py >>> k);
                    n_y[k+1][l] = py - (px >>> k);
                    n_z[k+1][l] = pz + tcc_pkg::atan_step(k);
                end else begin
                    n_x[k+1][l] = px - (py >>> k);
                    n_y[k+1][l] = py + (px >>> k);
                    n_z[k+1][l] = pz - tcc_pkg::atan_step(k);
                end
            end
        end
    end

    always_comb begin
        logic signed [ZW-1:0] zc;
        logic signed [PW-1:0] pp;
        for (int l = 0; l < NL; l++) begin
            zc = r_z[NS][l];
            if (zc > tcc_pkg::ANG_180) begin
                zc = tcc_pkg::ANG_180;
            end
            if (zc < -tcc_pkg::ANG_180) begin
                zc = -tcc_pkg::ANG_180;
            end
            pp = (PW'(zc) <<< 3) + (PW'(zc) <<< 1);
            if (pp < 0) begin
                pp = pp + RND;
            end
            n_t[l] = TW'(pp >>> tcc_pkg::ANG_FRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[NS:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_fix <= n_fix;
            for (int k = 0; k < NS + 2; k++) begin
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
            r_t <= n_t;
        end
    end

    assign o_valid  = r_valid[NS+1];
    assign o_side   = r_side[NS+1];
    assign o_tenths = r_t;

endmodule

[rtl/tilt_compensated_compass_top.sv]
// Tilt-compensated compass: roll, pitch and negated heading in tenths of a degree.
// Depends on tcc_pkg, tcc_sqrt, tcc_div and tcc_cordic.
//
//   channel | direction | signals                                   | transfer when
//   sample  | in        | i_acc_x/y/z, i_mag_x/y/z, i_valid, o_stall | i_valid & !o_stall
//   angles  | out       | o_roll/pitch/heading_tenths, o_degenerate  | o_valid & !i_stall
//
// A new sample enters every cycle unless o_stall is high.
// The path runs through the two root units (one bit per stage), the Q1.15 divider
// (17 stages), three product stages and the 18-iteration CORDIC.
// Reset clears every valid bit; no other datapath register is reset.
// A stalled result freezes the whole pipeline, so nothing is dropped or repeated.
module tilt_compensated_compass_top #(
    parameter int SAMPLE_BITS = tcc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [SAMPLE_BITS-1:0]          i_acc_x,
    input  logic signed [SAMPLE_BITS-1:0]          i_acc_y,
    input  logic signed [SAMPLE_BITS-1:0]          i_acc_z,
    input  logic signed [SAMPLE_BITS-1:0]          i_mag_x,
    input  logic signed [SAMPLE_BITS-1:0]          i_mag_y,
    input  logic signed [SAMPLE_BITS-1:0]          i_mag_z,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [tcc_pkg::ROLL_BITS-1:0]   o_roll_tenths,
    output logic signed [tcc_pkg::ROLL_BITS-1:0]   o_pitch_tenths,
    output logic signed [tcc_pkg::TEN_BITS-1:0]    o_heading_tenths,
    output logic                                   o_degenerate
);
    localparam int SB  = SAMPLE_BITS;
    localparam int QB  = tcc_pkg::Q_BITS;
    localparam int HW  = SB + 32;
    localparam int MW3 = 3 * SB;
    localparam int SW1 = 2 * SB + 3 + MW3;
    localparam int SW2 = MW3 + 1;
    localparam int SW3 = 2 * QB + MW3 + 1;
    localparam int RB  = tcc_pkg::ROLL_BITS;
    localparam int TB  = tcc_pkg::TEN_BITS;

    logic en;

    // squares
    logic                     r_s1_valid;
    logic signed [2*SB-1:0]   r_s1_sqx, r_s1_sqy, r_s1_sqz;
    logic signed [SB-1:0]     r_s1_ax, r_s1_ay;
    logic [MW3-1:0]           r_s1_m;

    // sums, magnitudes
    logic                     r_s2_valid;
    logic [2*SB-1:0]          r_s2_ryz2, r_s2_n2;
    logic [SB-1:0]            r_s2_magy, r_s2_magx;
    logic                     r_s2_negy, r_s2_negp, r_s2_deg;
    logic [MW3-1:0]           r_s2_m;

    logic [2*SB-1:0]          w_rt_in [2];
    logic [SB-1:0]            w_rt_out [2];
    logic                     w_rt_valid;
    logic [SW1-1:0]           w_rt_side;
    logic [SB-1:0]            w_rt_magy, w_rt_magx;
    logic                     w_rt_negy, w_rt_negp;
    logic [SW2-1:0]           w_rt_tail;
    logic [SB-1:0]            w_dv_mag [2];

    logic                     w_dv_valid;
    logic [SW2-1:0]           w_dv_side;
    logic signed [QB-1:0]     w_dv_q [2];

    // sine squares
    logic                     r_c1_valid;
    logic signed [QB-1:0]     r_c1_s [2];
    logic signed [31:0]       r_c1_s2 [2];
    logic [SW2-1:0]           r_c1_side;

    logic [31:0]              w_cs_in [2];
    logic [QB-1:0]            w_cs_out [2];
    logic                     w_cs_valid;
    logic [SW3-1:0]           w_cs_side;
    logic [QB-1:0]            w_cs_sr, w_cs_sp;
    logic                     w_cs_deg;
    logic [MW3-1:0]           w_cs_m;

    // saturated cosines
    logic                     r_c2_valid, r_c2_deg;
    logic signed [QB-1:0]     r_c2_sr, r_c2_sp, r_c2_cr, r_c2_cp;
    logic signed [SB-1:0]     r_c2_mx, r_c2_my, r_c2_mz;

    // product stages; angle order: sr, cr, sp, cp
    logic                     r_p1_valid, r_p1_deg;
    logic signed [31:0]       r_p1_srsp, r_p1_srcp;
    logic signed [SB+15:0]    r_p1_mxcp, r_p1_mzsp, r_p1_mycr;
    logic signed [SB-1:0]     r_p1_mx, r_p1_mz;
    logic signed [QB-1:0]     r_p1_ang [4];

    logic                     r_p2_valid, r_p2_deg;
    logic signed [HW-1:0]     r_p2_t1, r_p2_t3;
    logic signed [SB+16:0]    r_p2_sxz;
    logic signed [SB+15:0]    r_p2_t2;
    logic signed [QB-1:0]     r_p2_ang [4];

    logic                     r_p3_valid, r_p3_deg;
    logic signed [HW-1:0]     r_p3_tx, r_p3_ty;
    logic signed [QB-1:0]     r_p3_ang [4];

    logic signed [HW-1:0]     w_cd_x [3];
    logic signed [HW-1:0]     w_cd_y [3];
    logic                     w_cd_valid;
    logic                     w_cd_deg;
    logic signed [TB-1:0]     w_cd_t [3];

    logic                     r_o_valid, r_o_deg;
    logic signed [RB-1:0]     r_o_roll, r_o_pitch;
    logic signed [TB-1:0]     r_o_head;

    assign en      = !(r_o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_c1_valid <= 1'b0;
            r_c2_valid <= 1'b0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_c1_valid <= w_dv_valid;
            r_c2_valid <= w_cs_valid;
            r_p1_valid <= r_c2_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_o_valid  <= w_cd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sqx <= (2*SB)'(i_acc_x) * (2*SB)'(i_acc_x);
            r_s1_sqy <= (2*SB)'(i_acc_y) * (2*SB)'(i_acc_y);
            r_s1_sqz <= (2*SB)'(i_acc_z) * (2*SB)'(i_acc_z);
            r_s1_ax  <= i_acc_x;
            r_s1_ay  <= i_acc_y;
            r_s1_m   <= {i_mag_x, i_mag_y, i_mag_z};

            r_s2_ryz2 <= $unsigned(r_s1_sqy) + $unsigned(r_s1_sqz);
            r_s2_n2   <= $unsigned(r_s1_sqy) + $unsigned(r_s1_sqz) + $unsigned(r_s1_sqx);
            r_s2_deg  <= ($unsigned(r_s1_sqy) + $unsigned(r_s1_sqz)) == '0;
            r_s2_magy <= r_s1_ay[SB-1] ? SB'(-r_s1_ay) : SB'(r_s1_ay);
            r_s2_negy <= r_s1_ay[SB-1];
            r_s2_magx <= r_s1_ax[SB-1] ? SB'(-r_s1_ax) : SB'(r_s1_ax);
            r_s2_negp <= !r_s1_ax[SB-1] && (r_s1_ax != '0);
            r_s2_m    <= r_s1_m;

            for (int l = 0; l < 2; l++) begin
                r_c1_s[l]  <= w_dv_q[l];
                r_c1_s2[l] <= 32'(w_dv_q[l]) * 32'(w_dv_q[l]);
            end
            r_c1_side <= w_dv_side;

            r_c2_sr  <= $signed(w_cs_sr);
            r_c2_sp  <= $signed(w_cs_sp);
            r_c2_cr  <= w_cs_out[0][QB-1] ? $signed(tcc_pkg::Q15_MAX) : $signed(w_cs_out[0]);
            r_c2_cp  <= w_cs_out[1][QB-1] ? $signed(tcc_pkg::Q15_MAX) : $signed(w_cs_out[1]);
            r_c2_deg <= w_cs_deg;
            r_c2_mx  <= $signed(w_cs_m[MW3-1:2*SB]);
            r_c2_my  <= $signed(w_cs_m[2*SB-1:SB]);
            r_c2_mz  <= $signed(w_cs_m[SB-1:0]);

            r_p1_srsp   <= 32'(r_c2_sr) * 32'(r_c2_sp);
            r_p1_srcp   <= 32'(r_c2_sr) * 32'(r_c2_cp);
            r_p1_mxcp   <= (SB+16)'(r_c2_mx) * (SB+16)'(r_c2_cp);
            r_p1_mzsp   <= (SB+16)'(r_c2_mz) * (SB+16)'(r_c2_sp);
            r_p1_mycr   <= (SB+16)'(r_c2_my) * (SB+16)'(r_c2_cr);
            r_p1_mx     <= r_c2_mx;
            r_p1_mz     <= r_c2_mz;
            r_p1_deg    <= r_c2_deg;
            r_p1_ang[0] <= r_c2_sr;
            r_p1_ang[1] <= r_c2_cr;
            r_p1_ang[2] <= r_c2_sp;
            r_p1_ang[3] <= r_c2_cp;

            r_p2_t1  <= HW'(r_p1_mx) * HW'(r_p1_srsp);
            r_p2_t3  <= HW'(r_p1_mz) * HW'(r_p1_srcp);
            r_p2_sxz <= (SB+17)'(r_p1_mxcp) + (SB+17)'(r_p1_mzsp);
            r_p2_t2  <= r_p1_mycr;
            r_p2_deg <= r_p1_deg;
            r_p2_ang <= r_p1_ang;

            r_p3_ty  <= r_p2_t1 + (HW'(r_p2_t2) <<< tcc_pkg::FRAC) - r_p2_t3;
            r_p3_tx  <= HW'(r_p2_sxz) <<< tcc_pkg::FRAC;
            r_p3_deg <= r_p2_deg;
            r_p3_ang <= r_p2_ang;

            r_o_deg   <= w_cd_deg;
            r_o_roll  <= w_cd_deg ? '0 : RB'(w_cd_t[1]);
            r_o_pitch <= w_cd_deg ? '0 : RB'(w_cd_t[2]);
            r_o_head  <= w_cd_deg ? '0 : -w_cd_t[0];
        end
    end

    assign w_rt_in[0] = r_s2_ryz2;
    assign w_rt_in[1] = r_s2_n2;

    tcc_sqrt #(
        .VW (2 * SB),
        .NL (2),
        .SW (SW1)
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_valid),
        .i_side  ({r_s2_magy, r_s2_negy, r_s2_magx, r_s2_negp, r_s2_deg, r_s2_m}),
        .i_val   (w_rt_in),
        .o_valid (w_rt_valid),
        .o_side  (w_rt_side),
        .o_root  (w_rt_out)
    );

    assign {w_rt_magy, w_rt_negy, w_rt_magx, w_rt_negp, w_rt_tail} = w_rt_side;
    assign w_dv_mag[0] = w_rt_magy;
    assign w_dv_mag[1] = w_rt_magx;

    tcc_div #(
        .MW (SB),
        .NL (2),
        .SW (SW2)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_rt_valid),
        .i_side  (w_rt_tail),
        .i_mag   (w_dv_mag),
        .i_den   (w_rt_out),
        .i_neg   ({w_rt_negp, w_rt_negy}),
        .o_valid (w_dv_valid),
        .o_side  (w_dv_side),
        .o_q     (w_dv_q)
    );

    assign w_cs_in[0] = tcc_pkg::Q30_ONE - $unsigned(r_c1_s2[0]);
    assign w_cs_in[1] = tcc_pkg::Q30_ONE - $unsigned(r_c1_s2[1]);

    tcc_sqrt #(
        .VW (32),
        .NL (2),
        .SW (SW3)
    ) u_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c1_valid),
        .i_side  ({r_c1_s[0], r_c1_s[1], r_c1_side}),
        .i_val   (w_cs_in),
        .o_valid (w_cs_valid),
        .o_side  (w_cs_side),
        .o_root  (w_cs_out)
    );

    assign {w_cs_sr, w_cs_sp, w_cs_deg, w_cs_m} = w_cs_side;

    assign w_cd_x[0] = r_p3_tx;
    assign w_cd_y[0] = r_p3_ty;
    assign w_cd_x[1] = HW'(r_p3_ang[1]);
    assign w_cd_y[1] = HW'(r_p3_ang[0]);
    assign w_cd_x[2] = HW'(r_p3_ang[3]);
    assign w_cd_y[2] = HW'(r_p3_ang[2]);

    tcc_cordic #(
        .IW (HW),
        .NL (3),
        .SW (1)
    ) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_p3_valid),
        .i_side   (r_p3_deg),
        .i_x      (w_cd_x),
        .i_y      (w_cd_y),
        .o_valid  (w_cd_valid),
        .o_side   (w_cd_deg),
        .o_tenths (w_cd_t)
    );

    assign o_valid          = r_o_valid;
    assign o_roll_tenths    = r_o_roll;
    assign o_pitch_tenths   = r_o_pitch;
    assign o_heading_tenths = r_o_head;
    assign o_degenerate     = r_o_deg;

    a_stall_only_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a waiting result");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_roll_tenths == 0 && o_pitch_tenths == 0 && o_heading_tenths == 0))
        else $error("degenerate result carries nonzero angles");

    a_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_tenths <= 900 && o_roll_tenths >= -900 &&
                     o_pitch_tenths <= 900 && o_pitch_tenths >= -900))
        else $error("roll or pitch out of range");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heading_tenths <= 1800 && o_heading_tenths >= -1800))
        else $error("heading out of range");

endmodule

[test/tb.sv]
// Testbench for tilt_compensated_compass_top: directed table then random sensor samples,
// each result checked against a behavioral predictor of roll, pitch and heading.
// Depends on tcc_pkg and the RTL under rtl/.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = tcc_pkg::SAMPLE_BITS_DEF;
    localparam int RB = tcc_pkg::ROLL_BITS;
    localparam int HB = tcc_pkg::TEN_BITS;
    localparam int RANDOM_SAMPLES = 1030;
    localparam longint ONE80 = 180 * 65536;

    typedef struct packed {
        logic signed [RB-1:0] roll;
        logic signed [RB-1:0] pitch;
        logic signed [HB-1:0] heading;
        logic                 degenerate;
    } t_angles;

    typedef struct {
        logic signed [SB-1:0] ax, ay, az, mx, my, mz;
        bit                   typed;
        t_angles              want;
    } t_sample_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [SB-1:0] i_acc_x = '0, i_acc_y = '0, i_acc_z = '0;
    logic signed [SB-1:0] i_mag_x = '0, i_mag_y = '0, i_mag_z = '0;
    logic o_stall, o_valid, o_degenerate;
    logic signed [RB-1:0] o_roll_tenths, o_pitch_tenths;
    logic signed [HB-1:0] o_heading_tenths;

    t_angles expected_angles[$];
    int      failures = 0;
    bit      quiet_phase = 1'b0;
    bit      hold_request = 1'b0;
    bit      hold_started = 1'b0;
    int      hold_cycles = 0;

    tilt_compensated_compass_top DUT (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint floor_root(longint v);
        longint r = 0;
        longint b = 64'sd1 << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint q15_sine(longint a, longint root);
        longint q = ((a < 0 ? -a : a) * 32768) / root;
        if (q > 32767) q = 32767;
        return a < 0 ? -q : q;
    endfunction

    function automatic longint q15_cosine(longint s);
        longint r = floor_root(64'sd1073741824 - s * s);
        return r > 32767 ? 32767 : r;
    endfunction

    function automatic longint arc_angle(longint y, longint x);
        longint z = 0;
        longint nx;
        if (y == 0) return x < 0 ? ONE80 : 0;
        if (x < 0) begin
            z = y > 0 ? ONE80 : -ONE80;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < tcc_pkg::CORDIC_STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(tcc_pkg::atan_step(i));
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(tcc_pkg::atan_step(i));
            end
            x = nx;
        end
        if (z > ONE80) z = ONE80;
        if (z < -ONE80) z = -ONE80;
        return z;
    endfunction

    function automatic longint tenths(longint ang);
        return (ang * 10) / 65536;
    endfunction

    function automatic t_angles predict_angles(longint ax, longint ay, longint az,
                                               longint mx, longint my, longint mz);
        t_angles r;
        longint yz2, n2, sr, cr, sp, cp, tx, ty;
        yz2 = ay * ay + az * az;
        n2 = yz2 + ax * ax;
        r = '0;
        if (yz2 == 0 || n2 == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        sr = q15_sine(ay, floor_root(yz2));
        cr = q15_cosine(sr);
        sp = q15_sine(-ax, floor_root(n2));
        cp = q15_cosine(sp);
        tx = (mx * cp + mz * sp) * 32768;
        ty = mx * (sr * sp) + my * cr * 32768 - mz * (sr * cp);
        r.heading = HB'(-tenths(arc_angle(ty, tx)));
        r.roll = RB'(tenths(arc_angle(sr, cr)));
        r.pitch = RB'(tenths(arc_angle(sp, cp)));
        return r;
    endfunction

    task automatic send_sample(t_sample_row s);
        t_angles p;
        if (!quiet_phase && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_acc_x <= s.ax; i_acc_y <= s.ay; i_acc_z <= s.az;
        i_mag_x <= s.mx; i_mag_y <= s.my; i_mag_z <= s.mz;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        p = predict_angles(s.ax, s.ay, s.az, s.mx, s.my, s.mz);
        if (s.typed && p != s.want) begin
            $error("table row disagrees with predictor: %h vs %h", s.want, p);
            failures++;
        end
        expected_angles.push_back(p);
    endtask

    function automatic t_sample_row mk(int ax, int ay, int az, int mx, int my, int mz,
                                       bit typed = 0, int roll = 0, int pitch = 0,
                                       int head = 0, bit degen = 0);
        t_sample_row s;
        s.ax = SB'(ax); s.ay = SB'(ay); s.az = SB'(az);
        s.mx = SB'(mx); s.my = SB'(my); s.mz = SB'(mz);
        s.typed = typed;
        s.want.roll = RB'(roll);
        s.want.pitch = RB'(pitch);
        s.want.heading = HB'(head);
        s.want.degenerate = degen;
        return s;
    endfunction

    function automatic logic signed [SB-1:0] rand_axis();
        case ($urandom_range(5))
            0: return SB'($urandom_range(0, 1) ? -32768 : 32767);
            1: return SB'($signed($urandom_range(0, 6)) - 3);
            default: return SB'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_angles e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_angles.size() == 0) begin
                $error("unexpected transfer on output");
                failures++;
            end else begin
                e = expected_angles.pop_front();
                if (o_roll_tenths !== e.roll) begin
                    $error("roll_tenths: expected %0d, actual %0d", e.roll, o_roll_tenths);
                    failures++;
                end
                if (o_pitch_tenths !== e.pitch) begin
                    $error("pitch_tenths: expected %0d, actual %0d", e.pitch, o_pitch_tenths);
                    failures++;
                end
                if (o_heading_tenths !== e.heading) begin
                    $error("heading_tenths: expected %0d, actual %0d", e.heading,
                           o_heading_tenths);
                    failures++;
                end
                if (o_degenerate !== e.degenerate) begin
                    $error("degenerate: expected %0d, actual %0d", e.degenerate,
                           o_degenerate);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_request && !hold_started) begin
            hold_started <= 1'b1;
            hold_cycles <= 150;
            i_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else if (!quiet_phase && $urandom_range(99) < 9) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        #(20ns * 400000);
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_sample_row dir_table[$];
        t_sample_row s;
        dir_table = '{
            mk(0, 0, 0, 100, 200, 300, 1, 0, 0, 0, 1),
            mk(500, 0, 0, -1, 2, 3, 1, 0, 0, 0, 1),
            mk(-32768, 0, 0, 32767, -32768, 0, 1, 0, 0, 0, 1),
            mk(0, 0, 1000, 0, 0, 0, 1, 0, 0, 0, 0),
            mk(0, 0, 1000, -1000, 0, 0, 1, 0, 0, -1800, 0),
            mk(0, 0, 1000, 1000, 0, 0, 1, 0, 0, 0, 0),
            mk(0, 1000, 0, 100, 100, 100),
            mk(0, -1000, 0, 100, 100, 100),
            mk(1000, 0, 0, 100, 100, 100, 1, 0, 0, 0, 1),
            mk(0, 0, -1000, 50, -50, 0),
            mk(-32768, -32768, -32768, -32768, -32768, -32768),
            mk(32767, 32767, 32767, 32767, 32767, 32767),
            mk(-32768, 32767, -32768, 32767, -32768, 32767),
            mk(32767, -32768, 32767, -32768, 32767, -32768),
            mk(1, 1, 1, 1, 1, 1),
            mk(-1, -1, -1, -1, -1, -1),
            mk(0, 0, 16384, 0, 20000, 0),
            mk(0, 0, 16384, 0, -20000, 0),
            mk(-16384, 0, 16384, 1000, 0, 1000),
            mk(16384, 16384, 0, -300, 700, -900)
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_table[k]) send_sample(dir_table[k]);
        i_valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge i_clk);
        for (int n = 0; n < RANDOM_SAMPLES; n++) begin
            if (n == 200) hold_request = 1'b1;
            if (n == 500) begin
                i_valid <= 1'b0;
                while (expected_angles.size() != 0) @(posedge i_clk);
            end
            quiet_phase = (n >= 700 && n < 850);
            s.ax = rand_axis(); s.ay = rand_axis(); s.az = rand_axis();
            s.mx = rand_axis(); s.my = rand_axis(); s.mz = rand_axis();
            if ($urandom_range(30) == 0) begin
                s.ay = '0;
                s.az = '0;
            end
            s.typed = 1'b0;
            send_sample(s);
        end
        quiet_phase = 1'b0;
        i_valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge i_clk);
        repeat (SB + 80) @(posedge i_clk);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

[tilt_compensated_compass_top.f]
rtl/tcc_pkg.sv
rtl/tcc_sqrt.sv
rtl/tcc_div.sv
rtl/tcc_cordic.sv
rtl/tilt_compensated_compass_top.sv
test/tb.sv
